@@ hw/rtl/mks_pkg.sv @@
// ----------------------------------------------------------------------------
// mks_pkg
// Shared types, constants, the microcode table and the Morse symbol table
// for the Morse keying sequencer.
// ----------------------------------------------------------------------------
package mks_pkg;

    // Line buffer capacity; characters beyond CAPACITY-1 on a line are dropped
    localparam int LINE_CAPACITY = 128;
    localparam int LINE_W        = $clog2(LINE_CAPACITY);
    localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(LINE_CAPACITY - 1);

    // Register reset values
    localparam logic [5:0] DOT_RESET    = 6'd2;
    localparam logic [7:0] LFLASH_RESET = 8'd2;
    localparam logic [7:0] SFLASH_RESET = 8'd10;

    // Configuration register indexes
    localparam logic [1:0] CFG_DOT    = 2'd0;
    localparam logic [1:0] CFG_LFLASH = 2'd1;
    localparam logic [1:0] CFG_SFLASH = 2'd2;

    // Character codes
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TILDE   = 8'd126;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [5:0] DIGIT_BASE = 6'd26;

    // Program counter and microcode addresses
    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_FETCH  = 3'd0;
    localparam pc_t PC_SENT   = 3'd1;
    localparam pc_t PC_SPACE  = 3'd2;
    localparam pc_t PC_SYM    = 3'd3;
    localparam pc_t PC_GAP    = 3'd4;
    localparam pc_t PC_LFLASH = 3'd5;
    localparam pc_t PC_LGAP   = 3'd6;

    // Character class; each code equals the address of its handler so that
    // dispatch jumps straight to it (no-output class returns to fetch)
    typedef logic [1:0] cls_t;
    localparam cls_t CLS_NONE  = 2'd0;
    localparam cls_t CLS_SENT  = 2'd1;
    localparam cls_t CLS_SPACE = 2'd2;
    localparam cls_t CLS_SYM   = 2'd3;

    // Jump kinds
    typedef logic [1:0] jmp_t;
    localparam jmp_t J_NEXT     = 2'd0;
    localparam jmp_t J_GOTO     = 2'd1;
    localparam jmp_t J_MORE     = 2'd2;  // next while symbols remain, else target
    localparam jmp_t J_DISPATCH = 2'd3;  // take an item, jump by its class

    // Segment kinds
    typedef logic [2:0] seg_t;
    localparam seg_t SEG_TONE   = 3'd0;
    localparam seg_t SEG_GAP    = 3'd1;
    localparam seg_t SEG_LFLASH = 3'd2;
    localparam seg_t SEG_LGAP   = 3'd3;
    localparam seg_t SEG_WORD   = 3'd4;
    localparam seg_t SEG_SENT   = 3'd5;

    typedef struct packed {
        logic emit;
        logic last;
        seg_t seg;
        jmp_t jmp;
        pc_t  target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        cls_t cls;
        logic sym_more;
        logic out_room;
    } stat_t;

    function automatic ctrl_t ucode(input pc_t pc);
        ctrl_t cw;
        cw = '{emit: 1'b0, last: 1'b0, seg: SEG_GAP, jmp: J_GOTO, target: PC_FETCH};
        case (pc)
            PC_FETCH:  cw = '{1'b0, 1'b0, SEG_GAP,    J_DISPATCH, PC_FETCH};
            PC_SENT:   cw = '{1'b1, 1'b1, SEG_SENT,   J_GOTO,     PC_FETCH};
            PC_SPACE:  cw = '{1'b1, 1'b1, SEG_WORD,   J_GOTO,     PC_FETCH};
            PC_SYM:    cw = '{1'b1, 1'b0, SEG_TONE,   J_MORE,     PC_LFLASH};
            PC_GAP:    cw = '{1'b1, 1'b0, SEG_GAP,    J_GOTO,     PC_SYM};
            PC_LFLASH: cw = '{1'b1, 1'b0, SEG_LFLASH, J_NEXT,     PC_FETCH};
            PC_LGAP:   cw = '{1'b1, 1'b1, SEG_LGAP,   J_GOTO,     PC_FETCH};
            default:   cw = '{1'b0, 1'b0, SEG_GAP,    J_GOTO,     PC_FETCH};
        endcase
        return cw;
    endfunction

    // Morse table: {symbol count[7:5], dash mask[4:0]}, first symbol in bit 0
    function automatic logic [7:0] morse_code(input logic [5:0] idx);
        logic [7:0] code;
        code = 8'd0;
        case (idx)
            6'd0:  code = {3'd2, 5'd2};
            6'd1:  code = {3'd4, 5'd1};
            6'd2:  code = {3'd4, 5'd5};
            6'd3:  code = {3'd3, 5'd1};
            6'd4:  code = {3'd1, 5'd0};
            6'd5:  code = {3'd4, 5'd4};
            6'd6:  code = {3'd3, 5'd3};
            6'd7:  code = {3'd4, 5'd0};
            6'd8:  code = {3'd2, 5'd0};
            6'd9:  code = {3'd4, 5'd14};
            6'd10: code = {3'd3, 5'd5};
            6'd11: code = {3'd4, 5'd2};
            6'd12: code = {3'd2, 5'd3};
            6'd13: code = {3'd2, 5'd1};
            6'd14: code = {3'd3, 5'd7};
            6'd15: code = {3'd4, 5'd6};
            6'd16: code = {3'd4, 5'd11};
            6'd17: code = {3'd3, 5'd2};
            6'd18: code = {3'd3, 5'd0};
            6'd19: code = {3'd1, 5'd1};
            6'd20: code = {3'd3, 5'd4};
            6'd21: code = {3'd4, 5'd8};
            6'd22: code = {3'd3, 5'd6};
            6'd23: code = {3'd4, 5'd9};
            6'd24: code = {3'd4, 5'd13};
            6'd25: code = {3'd4, 5'd3};
            6'd26: code = {3'd5, 5'd31};
            6'd27: code = {3'd5, 5'd30};
            6'd28: code = {3'd5, 5'd28};
            6'd29: code = {3'd5, 5'd24};
            6'd30: code = {3'd5, 5'd16};
            6'd31: code = {3'd5, 5'd0};
            6'd32: code = {3'd5, 5'd1};
            6'd33: code = {3'd5, 5'd3};
            6'd34: code = {3'd5, 5'd7};
            6'd35: code = {3'd5, 5'd15};
            default: code = 8'd0;
        endcase
        return code;
    endfunction

endpackage

@@ hw/rtl/mks_sequencer.sv @@
// ----------------------------------------------------------------------------
// mks_sequencer
// Step counter and microcode table; resolves jumps from datapath status.
// ----------------------------------------------------------------------------
module mks_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  mks_pkg::stat_t  stat,
    output mks_pkg::ctrl_t  ctrl
);

    mks_pkg::pc_t pc_reg;
    mks_pkg::pc_t pc_next;

    assign ctrl = mks_pkg::ucode(pc_reg);

    always_comb
    begin
        pc_next = pc_reg;
        if (!(ctrl.emit && !stat.out_room))
        begin
            case (ctrl.jmp)
                mks_pkg::J_NEXT:     pc_next = pc_reg + 1'b1;
                mks_pkg::J_GOTO:     pc_next = ctrl.target;
                mks_pkg::J_MORE:     pc_next = stat.sym_more ? pc_reg + 1'b1 : ctrl.target;
                mks_pkg::J_DISPATCH:
                begin
                    // hold at fetch until an item shows up
                    if (stat.in_valid)
                        pc_next = {1'b0, stat.cls};
                end
                default:             pc_next = mks_pkg::PC_FETCH;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= mks_pkg::PC_FETCH;
        else
            pc_reg <= pc_next;
    end

endmodule

@@ hw/rtl/mks_datapath.sv @@
// ----------------------------------------------------------------------------
// mks_datapath
// Character decode, line count, symbol shifter, duration select, output
// register and configuration registers.
// ----------------------------------------------------------------------------
module mks_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  mks_pkg::ctrl_t  ctrl,
    output mks_pkg::stat_t  stat,
    input  logic            in_valid,
    input  logic [7:0]      char_code,
    input  logic            cfg_valid,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_data,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            tone_on,
    output logic            letter_led,
    output logic            word_led,
    output logic            sentence_led,
    output logic [7:0]      duration_units,
    output logic            last_segment
);

    logic [5:0] dot_reg;
    logic [7:0] lflash_reg;
    logic [7:0] sflash_reg;

    logic [mks_pkg::LINE_W-1:0] line_reg;
    logic [mks_pkg::LINE_W-1:0] line_next;
    logic [4:0] bits_reg;
    logic [4:0] bits_next;
    logic [2:0] left_reg;
    logic [2:0] left_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic       tone_reg;
    logic       letter_reg;
    logic       word_reg;
    logic       sent_reg;
    logic [7:0] dur_reg;
    logic       last_reg;

    logic       take;
    logic       fire;
    logic       is_end;
    logic       printable;
    logic       is_upper;
    logic       is_lower;
    logic       is_digit;
    logic       line_room;
    logic [5:0] idx;
    logic [7:0] code;
    mks_pkg::cls_t cls;

    logic [7:0] dot3;
    logic [8:0] dot7;
    logic [7:0] dot7_sat;
    logic [7:0] dur;

    // ---- decode ----
    assign is_end    = (char_code == mks_pkg::CH_LF) || (char_code == mks_pkg::CH_CR);
    assign printable = (char_code >= mks_pkg::CH_SPACE) && (char_code <= mks_pkg::CH_TILDE);
    assign is_upper  = (char_code >= mks_pkg::CH_UPPER_A) && (char_code <= mks_pkg::CH_UPPER_Z);
    assign is_lower  = (char_code >= mks_pkg::CH_LOWER_A) && (char_code <= mks_pkg::CH_LOWER_Z);
    assign is_digit  = (char_code >= mks_pkg::CH_ZERO) && (char_code <= mks_pkg::CH_NINE);
    assign line_room = (line_reg != mks_pkg::LINE_LAST);

    always_comb
    begin
        idx = 6'd0;
        if (is_upper)
            idx = 6'(char_code - mks_pkg::CH_UPPER_A);
        else if (is_lower)
            idx = 6'(char_code - mks_pkg::CH_LOWER_A);
        else if (is_digit)
            idx = 6'(char_code - mks_pkg::CH_ZERO) + mks_pkg::DIGIT_BASE;
    end

    assign code = mks_pkg::morse_code(idx);

    always_comb
    begin
        cls = mks_pkg::CLS_NONE;
        if (is_end)
            cls = mks_pkg::CLS_SENT;
        else if (printable && line_room)
        begin
            if (char_code == mks_pkg::CH_SPACE)
                cls = mks_pkg::CLS_SPACE;
            else if (is_upper || is_lower || is_digit)
                cls = mks_pkg::CLS_SYM;
        end
    end

    assign take = in_valid && (ctrl.jmp == mks_pkg::J_DISPATCH);

    // ---- status ----
    assign stat.in_valid = in_valid;
    assign stat.cls      = cls;
    assign stat.sym_more = (left_reg > 3'd1);
    assign stat.out_room = !out_valid_reg || !out_stall;

    assign fire = ctrl.emit && stat.out_room;

    // ---- line count and symbol shifter ----
    always_comb
    begin
        line_next = line_reg;
        bits_next = bits_reg;
        left_next = left_reg;
        if (take)
        begin
            if (is_end)
                line_next = '0;
            else if (printable && line_room)
                line_next = line_reg + 1'b1;
            bits_next = code[4:0];
            left_next = code[7:5];
        end
        else if (fire && (ctrl.seg == mks_pkg::SEG_TONE))
        begin
            bits_next = {1'b0, bits_reg[4:1]};
            left_next = left_reg - 1'b1;
        end
    end

    // ---- durations ----
    assign dot3     = 8'({2'b00, dot_reg}) * 8'd3;
    assign dot7     = 9'({3'b000, dot_reg}) * 9'd7;
    assign dot7_sat = dot7[8] ? 8'hFF : dot7[7:0];

    always_comb
    begin
        case (ctrl.seg)
            mks_pkg::SEG_TONE:   dur = bits_reg[0] ? dot3 : {2'b00, dot_reg};
            mks_pkg::SEG_GAP:    dur = {2'b00, dot_reg};
            mks_pkg::SEG_LFLASH: dur = lflash_reg;
            mks_pkg::SEG_LGAP:   dur = dot3;
            mks_pkg::SEG_WORD:   dur = dot7_sat;
            mks_pkg::SEG_SENT:   dur = sflash_reg;
            default:             dur = 8'd0;
        endcase
    end

    // ---- output register ----
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            line_reg      <= '0;
            left_reg      <= 3'd0;
            dot_reg       <= mks_pkg::DOT_RESET;
            lflash_reg    <= mks_pkg::LFLASH_RESET;
            sflash_reg    <= mks_pkg::SFLASH_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            line_reg      <= line_next;
            left_reg      <= left_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    mks_pkg::CFG_DOT:    dot_reg    <= cfg_data[5:0];
                    mks_pkg::CFG_LFLASH: lflash_reg <= cfg_data;
                    mks_pkg::CFG_SFLASH: sflash_reg <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        if (fire)
        begin
            tone_reg   <= (ctrl.seg == mks_pkg::SEG_TONE);
            letter_reg <= (ctrl.seg == mks_pkg::SEG_LFLASH);
            word_reg   <= (ctrl.seg == mks_pkg::SEG_WORD);
            sent_reg   <= (ctrl.seg == mks_pkg::SEG_SENT);
            dur_reg    <= dur;
            last_reg   <= ctrl.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign tone_on        = tone_reg;
    assign letter_led     = letter_reg;
    assign word_led       = word_reg;
    assign sentence_led   = sent_reg;
    assign duration_units = dur_reg;
    assign last_segment   = last_reg;

endmodule

@@ hw/rtl/morse_keying_sequencer.sv @@
// ----------------------------------------------------------------------------
// morse_keying_sequencer
// Turns ASCII characters into timed Morse keying segments.
// ----------------------------------------------------------------------------
// One character is taken per item at the fetch step of a small microcode
// program; each later step emits one segment into the output register: a
// letter or digit of n symbols (at most 5) gives n tones, n-1 gaps, a letter
// flash and a letter gap, a space or line end gives one segment, and any
// other byte none. The program counter walks one step per cycle and holds
// while the output register is stalled. Configuration writes are always
// ready and take effect on segments emitted after the write.
module morse_keying_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       tone_on,
    output logic       letter_led,
    output logic       word_led,
    output logic       sentence_led,
    output logic [7:0] duration_units,
    output logic       last_segment
);

    mks_pkg::ctrl_t ctrl;
    mks_pkg::stat_t stat;

    assign in_stall  = (ctrl.jmp != mks_pkg::J_DISPATCH);
    assign cfg_ready = 1'b1;

    mks_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    mks_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .in_valid       (in_valid),
        .char_code      (char_code),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tone_on        (tone_on),
        .letter_led     (letter_led),
        .word_led       (word_led),
        .sentence_led   (sentence_led),
        .duration_units (duration_units),
        .last_segment   (last_segment)
    );

endmodule
